[rtl/core/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int NRES_W          = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W          = 32;
    localparam int ID_W            = 8;
    localparam int DELAY_W         = 16;
    localparam int FIFO_DEPTH      = 4;

    // item operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    // result kinds
    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic               op;
        logic [ID_W-1:0]    task_id;
        logic [DELAY_W-1:0] delay;
    } t_item;

endpackage

[rtl/core/dtq_front.sv]
// ----------------------------------------------------------------------------
// dtq_front
// Accepts input beats, decodes the operation and queues them for the back end.
// ----------------------------------------------------------------------------
module dtq_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_mode,
    input  logic [dtq_pkg::ID_W-1:0]     i_task_id,
    input  logic [dtq_pkg::DELAY_W-1:0]  i_delay_ticks,
    output logic                         o_item_v,
    output dtq_pkg::t_item               o_item,
    input  logic                         i_item_take
);

    localparam int PTR_W = $clog2(dtq_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(dtq_pkg::FIFO_DEPTH + 1);

    dtq_pkg::t_item r_fifo [dtq_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    dtq_pkg::t_item   w_in;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_in.op      = i_mode ? dtq_pkg::OP_SCHED : dtq_pkg::OP_TICK;
        w_in.task_id = i_task_id;
        w_in.delay   = i_delay_ticks;
    end

    assign o_stall  = (r_count == CNT_W'(dtq_pkg::FIFO_DEPTH));
    assign w_push   = i_valid && !o_stall;
    assign o_item_v = (r_count != '0);
    assign w_pop    = o_item_v && i_item_take;
    assign o_item   = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/dtq_tree.sv]
// ----------------------------------------------------------------------------
// dtq_tree
// Registered selection tree: finds the due slot with the largest age,
// lower slot wins on a tie. One register level per tree level.
// ----------------------------------------------------------------------------
module dtq_tree #(
    parameter int DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [DEPTH-1:0]                           i_leaf_v,
    input  logic [DEPTH-1:0][dtq_pkg::TIME_W-1:0]      i_leaf_age,
    input  logic [DEPTH-1:0][dtq_pkg::ID_W-1:0]        i_leaf_task,
    output logic                                       o_root_v,
    output logic [$clog2(DEPTH)-1:0]                   o_root_idx,
    output logic [dtq_pkg::ID_W-1:0]                   o_root_task
);

    localparam int LEVELS = $clog2(DEPTH);
    localparam int NPAD   = 1 << LEVELS;
    localparam int IW     = LEVELS;

    // node j has children 2j and 2j+1; nodes NPAD and up are leaves
    logic                        w_v    [1:2*NPAD-1];
    logic [dtq_pkg::TIME_W-1:0]  w_age  [1:2*NPAD-1];
    logic [IW-1:0]               w_idx  [1:2*NPAD-1];
    logic [dtq_pkg::ID_W-1:0]    w_task [1:2*NPAD-1];
    logic                        w_sel  [1:NPAD-1];

    logic                        r_v    [1:NPAD-1];
    logic [dtq_pkg::TIME_W-1:0]  r_age  [1:NPAD-1];
    logic [IW-1:0]               r_idx  [1:NPAD-1];
    logic [dtq_pkg::ID_W-1:0]    r_task [1:NPAD-1];

    always_comb begin
        for (int j = 1; j < NPAD; j++) begin
            w_v[j]    = r_v[j];
            w_age[j]  = r_age[j];
            w_idx[j]  = r_idx[j];
            w_task[j] = r_task[j];
        end
        for (int j = NPAD; j < 2 * NPAD; j++) begin
            w_idx[j] = IW'(j - NPAD);
            if (j - NPAD < DEPTH) begin
                w_v[j]    = i_leaf_v[IW'(j - NPAD)];
                w_age[j]  = i_leaf_age[IW'(j - NPAD)];
                w_task[j] = i_leaf_task[IW'(j - NPAD)];
            end else begin
                w_v[j]    = 1'b0;
                w_age[j]  = '0;
                w_task[j] = '0;
            end
        end
        // right child wins only when strictly older
        for (int j = 1; j < NPAD; j++) begin
            w_sel[j] = w_v[2*j+1] && (!w_v[2*j] || (w_age[2*j+1] > w_age[2*j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j < NPAD; j++) begin
                r_v[j] <= 1'b0;
            end
        end else begin
            for (int j = 1; j < NPAD; j++) begin
                r_v[j] <= w_v[2*j] || w_v[2*j+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 1; j < NPAD; j++) begin
            r_age[j]  <= w_sel[j] ? w_age[2*j+1]  : w_age[2*j];
            r_idx[j]  <= w_sel[j] ? w_idx[2*j+1]  : w_idx[2*j];
            r_task[j] <= w_sel[j] ? w_task[2*j+1] : w_task[2*j];
        end
    end

    assign o_root_v    = r_v[1];
    assign o_root_idx  = r_idx[1];
    assign o_root_task = r_task[1];

endmodule

[rtl/core/dtq_back.sv]
// ----------------------------------------------------------------------------
// dtq_back
// Slot store, time counter and release sequencer, with the result register.
// ----------------------------------------------------------------------------
module dtq_back #(
    parameter int DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_v,
    input  dtq_pkg::t_item             i_item,
    output logic                       o_item_take,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_kind,
    output logic [dtq_pkg::ID_W-1:0]   o_fired_id,
    output logic                       o_last
);

    localparam int LEVELS = $clog2(DEPTH);
    localparam int IW     = LEVELS;
    localparam int CNT_W  = $clog2(LEVELS + 2);
    localparam int TW     = dtq_pkg::TIME_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PICK = 1'b1;

    logic                            r_state;
    logic [CNT_W-1:0]                r_cnt;
    logic [dtq_pkg::NRES_W-1:0]      r_nres;
    logic [TW-1:0]                   r_time;
    logic [DEPTH-1:0]                r_valid;
    logic [DEPTH-1:0][TW-1:0]        r_deadline;
    logic [DEPTH-1:0][dtq_pkg::ID_W-1:0] r_task;
    logic [DEPTH-1:0][TW-1:0]        r_lf_age;
    logic [DEPTH-1:0]                r_lf_due;
    logic                            r_hold_v;
    logic [dtq_pkg::ID_W-1:0]        r_hold_id;

    logic                            r_out_v;
    logic                            r_out_kind;
    logic [dtq_pkg::ID_W-1:0]        r_out_id;
    logic                            r_out_last;

    logic                            w_root_v;
    logic [IW-1:0]                   w_root_idx;
    logic [dtq_pkg::ID_W-1:0]        w_root_task;
    logic [IW-1:0]                   w_free_idx;
    logic                            w_full;
    logic                            w_out_free;
    logic                            w_more;
    logic                            w_decide;
    logic                            w_pick;
    logic                            w_push;
    logic                            w_push_kind;
    logic [dtq_pkg::ID_W-1:0]        w_push_id;
    logic                            w_push_last;
    logic [TW-1:0]                   w_ahead [DEPTH];

    dtq_tree #(
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_leaf_v    (r_valid & r_lf_due),
        .i_leaf_age  (r_lf_age),
        .i_leaf_task (r_task),
        .o_root_v    (w_root_v),
        .o_root_idx  (w_root_idx),
        .o_root_task (w_root_task)
    );

    // lowest free slot
    always_comb begin
        w_free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = IW'(i);
            end
        end
        w_full = &r_valid;
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ahead[i] = r_deadline[i] - r_time;
        end
    end

    // leaf age and due flag are registered, so they follow time and deadlines in the next cycle
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_lf_age[i] <= r_time - r_deadline[i];
            r_lf_due[i] <= (w_ahead[i] == '0) || w_ahead[i][TW-1];
        end
    end

    assign w_out_free  = !r_out_v || !i_stall;
    assign o_item_take = (r_state == ST_IDLE) && i_item_v &&
                         !((i_item.op == dtq_pkg::OP_SCHED) && w_full && !w_out_free);

    assign w_more   = w_root_v && (r_nres < dtq_pkg::NRES_W'(dtq_pkg::MAX_RESULTS));
    assign w_decide = (r_state == ST_PICK) && (r_cnt == '0) && (!r_hold_v || w_out_free);
    assign w_pick   = w_decide && w_more;

    always_comb begin
        w_push      = 1'b0;
        w_push_kind = dtq_pkg::KIND_FIRED;
        w_push_id   = r_hold_id;
        w_push_last = !w_more;
        if (o_item_take && (i_item.op == dtq_pkg::OP_SCHED) && w_full) begin
            w_push      = 1'b1;
            w_push_kind = dtq_pkg::KIND_REJECT;
            w_push_id   = i_item.task_id;
            w_push_last = 1'b1;
        end else if (w_decide && r_hold_v) begin
            w_push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take && (i_item.op == dtq_pkg::OP_SCHED) && !w_full) begin
            r_deadline[w_free_idx] <= r_time + TW'(i_item.delay);
            r_task[w_free_idx]     <= i_item.task_id;
        end
        if (w_pick) begin
            r_hold_id <= w_root_task;
        end
        if (w_push) begin
            r_out_kind <= w_push_kind;
            r_out_id   <= w_push_id;
            r_out_last <= w_push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_nres   <= '0;
            r_time   <= '0;
            r_valid  <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_item_take) begin
                        if (i_item.op == dtq_pkg::OP_TICK) begin
                            r_time   <= r_time + TW'(1);
                            r_cnt    <= CNT_W'(LEVELS + 1);
                            r_nres   <= '0;
                            r_hold_v <= 1'b0;
                            r_state  <= ST_PICK;
                        end else if (!w_full) begin
                            r_valid[w_free_idx] <= 1'b1;
                        end
                    end
                end
                ST_PICK: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else if (w_decide) begin
                        if (w_more) begin
                            r_valid[w_root_idx] <= 1'b0;
                            r_hold_v <= 1'b1;
                            r_nres   <= r_nres + dtq_pkg::NRES_W'(1);
                            r_cnt    <= CNT_W'(LEVELS);
                        end else begin
                            r_hold_v <= 1'b0;
                            r_state  <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_out_v;
    assign o_kind     = r_out_kind;
    assign o_fired_id = r_out_id;
    assign o_last     = r_out_last;

`ifndef SYNTH
    a_pick_valid_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pick |-> r_valid[w_root_idx])
        else $error("released slot was not occupied");

    a_pick_clears_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pick |=> !r_valid[$past(w_root_idx)])
        else $error("released slot still occupied");

    a_reject_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (w_push_kind == dtq_pkg::KIND_REJECT)) |-> w_full)
        else $error("schedule rejected with a free slot");

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= dtq_pkg::NRES_W'(dtq_pkg::MAX_RESULTS))
        else $error("too many releases in one tick");
`endif

endmodule

[rtl/core/deadline_timer_queue.sv]
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Timer queue ordered by deadline, with a decoupled intake queue and release
// sequencer.
// ----------------------------------------------------------------------------
// A schedule beat stores a task in the lowest free slot with deadline = time +
// delay, or returns one reject result when every slot is taken. A tick beat
// advances time and then releases every due task, up to MAX_RESULTS per tick,
// oldest deadline first, lower slot on a tie, the final one flagged last.
// With L = log2(QUEUE_DEPTH) levels in the registered selection tree, each
// release waits for the tree to settle after the slot is cleared, and output
// stalls hold the back end further. A four-entry intake queue keeps taking
// beats while a tick is being worked off, and a hold register keeps one
// released task until the result register is free.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_mode,
    input  logic [dtq_pkg::ID_W-1:0]     i_task_id,
    input  logic [dtq_pkg::DELAY_W-1:0]  i_delay_ticks,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_kind,
    output logic [dtq_pkg::ID_W-1:0]     o_fired_id,
    output logic                         o_last
);

    logic           w_item_v;
    dtq_pkg::t_item w_item;
    logic           w_item_take;

    dtq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_task_id     (i_task_id),
        .i_delay_ticks (i_delay_ticks),
        .o_item_v      (w_item_v),
        .o_item        (w_item),
        .i_item_take   (w_item_take)
    );

    dtq_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_v    (w_item_v),
        .i_item      (w_item),
        .o_item_take (w_item_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_fired_id  (o_fired_id),
        .o_last      (o_last)
    );

endmodule

[tb/deadline_timer_queue_tb.sv]
// ----------------------------------------------------------------------------
// deadline_timer_queue_tb
// Self-checking bench for the deadline timer queue. A short directed opening
// and then random schedule/tick traffic are sent in bursts. Every result beat
// is checked in order against a behavioral copy of the queue kept in the
// bench, while the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module deadline_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = dtq_pkg::QUEUE_DEPTH_DEF;
    localparam int RANDOM_BEATS  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 40;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_CYCLES  = 50000;

    typedef struct packed {
        logic                     kind;
        logic [dtq_pkg::ID_W-1:0] id;
        logic                     last;
    } t_result;

    typedef enum logic [1:0] {FLOW, CHOPPY, CLOGGED} t_drain_style;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_valid       = 1'b0;
    logic                        i_mode        = dtq_pkg::OP_TICK;
    logic [dtq_pkg::ID_W-1:0]    i_task_id     = '0;
    logic [dtq_pkg::DELAY_W-1:0] i_delay_ticks = '0;
    logic                        i_stall       = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic                        o_kind;
    logic [dtq_pkg::ID_W-1:0]    o_fired_id;
    logic                        o_last;

    // behavioral copy of the timer queue
    bit [dtq_pkg::TIME_W-1:0]    now_ticks;
    bit [dtq_pkg::TIME_W-1:0]    slot_deadline [DEPTH];
    bit [dtq_pkg::ID_W-1:0]      slot_task     [DEPTH];
    bit                          slot_busy     [DEPTH];

    dtq_pkg::t_item      item_backlog [$];
    t_result             due_results  [$];
    int                  err_count    = 0;
    int                  results_seen = 0;

    int                  burst_left = 1;
    int                  gap_left   = 0;
    int                  hold_left  = 0;
    bit                  hold_done  = 1'b0;
    int                  style_left = 0;
    t_drain_style        style      = FLOW;

    deadline_timer_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_task_id     (i_task_id),
        .i_delay_ticks (i_delay_ticks),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_fired_id    (o_fired_id),
        .o_last        (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        err_count++;
    endtask

    // apply one accepted beat to the queue copy and record the results it owes
    task automatic advance_timer_queue(input dtq_pkg::t_item it);
        bit [dtq_pkg::TIME_W-1:0] ahead;
        bit [dtq_pkg::TIME_W-1:0] age;
        bit [dtq_pkg::TIME_W-1:0] best_age;
        bit [dtq_pkg::ID_W-1:0]   fired [dtq_pkg::MAX_RESULTS];
        t_result                  r;
        int                       best;
        int                       n;
        int                       slot;
        bit                       stored;
        bit                       scanning;
        stored   = 1'b0;
        scanning = 1'b1;
        n        = 0;
        if (it.op == dtq_pkg::OP_SCHED) begin
            for (slot = 0; slot < DEPTH; slot++) begin
                if (!slot_busy[slot] && !stored) begin
                    slot_busy[slot]     = 1'b1;
                    slot_task[slot]     = it.task_id;
                    slot_deadline[slot] = now_ticks + dtq_pkg::TIME_W'(it.delay);
                    stored              = 1'b1;
                end
            end
            if (!stored) begin
                r.kind = dtq_pkg::KIND_REJECT;
                r.id   = it.task_id;
                r.last = 1'b1;
                due_results.push_back(r);
            end
        end else begin
            now_ticks = now_ticks + dtq_pkg::TIME_W'(1);
            while (scanning && n < dtq_pkg::MAX_RESULTS) begin
                best     = -1;
                best_age = '0;
                for (slot = 0; slot < DEPTH; slot++) begin
                    if (slot_busy[slot]) begin
                        ahead = slot_deadline[slot] - now_ticks;
                        age   = now_ticks - slot_deadline[slot];
                        // due once the wrapped difference is zero or negative
                        if ((ahead == '0 || ahead[dtq_pkg::TIME_W-1]) &&
                            (best < 0 || age > best_age)) begin
                            best     = slot;
                            best_age = age;
                        end
                    end
                end
                if (best < 0) begin
                    scanning = 1'b0;
                end else begin
                    slot_busy[best] = 1'b0;
                    fired[n]        = slot_task[best];
                    n++;
                end
            end
            for (slot = 0; slot < n; slot++) begin
                r.kind = dtq_pkg::KIND_FIRED;
                r.id   = fired[slot];
                r.last = (slot == n - 1);
                due_results.push_back(r);
            end
        end
    endtask

    function automatic void queue_beat(input logic op,
                                       input logic [dtq_pkg::ID_W-1:0] id,
                                       input logic [dtq_pkg::DELAY_W-1:0] dly);
        dtq_pkg::t_item it;
        it.op      = op;
        it.task_id = id;
        it.delay   = dly;
        item_backlog.push_back(it);
    endfunction

    function automatic logic [dtq_pkg::DELAY_W-1:0] short_delay();
        return dtq_pkg::DELAY_W'($urandom_range(0, 7));
    endfunction

    // sender: bursts of random length with random gaps in between
    always @(posedge i_clk) begin : driver
        dtq_pkg::t_item taken;
        dtq_pkg::t_item nxt;
        if (i_rst_n && i_valid && o_stall === 1'b0) begin
            taken.op      = i_mode;
            taken.task_id = i_task_id;
            taken.delay   = i_delay_ticks;
            advance_timer_queue(taken);
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_stall !== 1'b0) begin
            // stalled beat stays as it is
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid  <= 1'b0;
        end else if (item_backlog.size() > 0) begin
            nxt           = item_backlog.pop_front();
            i_valid       <= 1'b1;
            i_mode        <= nxt.op;
            i_task_id     <= nxt.task_id;
            i_delay_ticks <= nxt.delay;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 30);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with one long hold-off to back the block up
    always @(posedge i_clk) begin : receiver
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            if (style_left == 0) begin
                style      <= t_drain_style'($urandom_range(0, 2));
                style_left <= $urandom_range(10, 80);
            end else begin
                style_left <= style_left - 1;
            end
            case (style)
                FLOW:    i_stall <= 1'b0;
                CHOPPY:  i_stall <= 1'($urandom_range(0, 1));
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            results_seen <= results_seen + 1;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result beat, id", int'(o_fired_id), 0);
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", int'(o_kind), int'(want.kind));
                if (o_fired_id !== want.id)
                    report_mismatch("fired_id", int'(o_fired_id), int'(want.id));
                if (o_last !== want.last)
                    report_mismatch("last", int'(o_last), int'(want.last));
            end
        end
    end

    initial begin : stimulus
        int i;
        int k;
        int target;
        int long_budget;
        int drain;
        logic op;
        logic [dtq_pkg::DELAY_W-1:0] dly;

        // zero delay fires on the next tick, then a tick with nothing due
        queue_beat(dtq_pkg::OP_SCHED, 8'h00, 16'h0000);
        queue_beat(dtq_pkg::OP_TICK, 8'hFF, 16'hFFFF);
        queue_beat(dtq_pkg::OP_TICK, 8'h00, 16'h0000);
        // fill every slot, one more is rejected, then all release on one tick
        for (i = 0; i < DEPTH; i++)
            queue_beat(dtq_pkg::OP_SCHED, dtq_pkg::ID_W'(8'h10 + i), 16'h0001);
        queue_beat(dtq_pkg::OP_SCHED, 8'hA5, 16'h0003);
        queue_beat(dtq_pkg::OP_TICK, 8'h5A, 16'h1234);
        // far deadline parks one slot for the whole run
        queue_beat(dtq_pkg::OP_SCHED, 8'hFF, 16'hFFFF);
        // later slot due earlier goes first
        queue_beat(dtq_pkg::OP_SCHED, 8'h33, 16'h0002);
        queue_beat(dtq_pkg::OP_SCHED, 8'h44, 16'h0001);
        queue_beat(dtq_pkg::OP_TICK, 8'h00, 16'h0000);
        queue_beat(dtq_pkg::OP_TICK, 8'h00, 16'h0000);

        target      = item_backlog.size() + RANDOM_BEATS;
        long_budget = 3;
        while (item_backlog.size() < target) begin
            if ($urandom_range(0, 9) < 8) begin
                // run of schedules followed by ticks that let them fire
                k = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 5);
                for (i = 0; i < k; i++)
                    queue_beat(dtq_pkg::OP_SCHED, dtq_pkg::ID_W'($urandom), short_delay());
                k = $urandom_range(1, 5);
                for (i = 0; i < k; i++)
                    queue_beat(dtq_pkg::OP_TICK, dtq_pkg::ID_W'($urandom),
                               dtq_pkg::DELAY_W'($urandom));
            end else begin
                op  = 1'($urandom_range(0, 1));
                dly = short_delay();
                if (op == dtq_pkg::OP_SCHED && long_budget > 0 &&
                    $urandom_range(0, 3) == 0) begin
                    dly = dtq_pkg::DELAY_W'($urandom);
                    long_budget--;
                end else if (op == dtq_pkg::OP_TICK) begin
                    dly = dtq_pkg::DELAY_W'($urandom);
                end
                queue_beat(op, dtq_pkg::ID_W'($urandom), dly);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (item_backlog.size() > 0 || i_valid)
            @(posedge i_clk);
        drain = 0;
        while (due_results.size() > 0 && drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_results.size() > 0)
            report_mismatch("results still owed", due_results.size(), 0);

        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
